// File: sv/m4pu_pkg.sv
`default_nettype none

package m4pu_pkg;

    localparam int DATA_W    = 32;
    localparam int IDX_W     = 4;
    localparam int MODE_W    = 3;
    localparam int FRAC_BITS = 16;
    localparam int LANES     = 4;
    localparam int LANE_AW   = $clog2(LANES);

    // Exact dot product widths: 64-bit products, two levels of pair sums.
    localparam int PROD_W = 2 * DATA_W;
    localparam int PAIR_W = PROD_W + 1;
    localparam int ACC_W  = PROD_W + 2;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    localparam int RESQ_DEPTH = 8;
    localparam int RESQ_AW    = $clog2(RESQ_DEPTH);
    localparam int RESQ_CW    = $clog2(RESQ_DEPTH + 1);

    // Four pipeline stages sit in front of the result queue.
    localparam int OCC_W = $clog2(RESQ_DEPTH + LANES + 1);

    localparam logic [MODE_W-1:0] MODE_LOAD_LEFT  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_RIGHT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MAT        = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MVEC       = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SCALE      = 3'd4;

    localparam logic [IDX_W-1:0] MVEC_LAST = 4'd3;
    localparam logic [IDX_W-1:0] MAT_LAST  = 4'd15;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        OP_LOAD_L,
        OP_LOAD_R,
        OP_MAT,
        OP_MVEC,
        OP_SCALE
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [IDX_W-1:0]         index;
        logic                     last;
    } res_t;

endpackage

`default_nettype wire

// File: sv/matrix4_product_unit.sv
`default_nettype none

// 4x4 signed Q16.16 matrix product unit. Both operand stores are column-major
// (index = column*4 + row). Push a word with mode 0 or 1 to load one element of
// the left matrix or the right store; loads produce no output. Mode 2 returns
// left x right (16 words), mode 3 returns left x the vector in right-store
// entries 0..3 (4 words, index = row), mode 4 returns left x value (16 words).
// Output words come in column-major order with last set on the final one.
// Each result is the exact sum of its products, floor-shifted right by 16 and
// saturated to 32 bits. Modes 5..7 are accepted and dropped. A load is applied
// when the engine takes it; a command holds the engine to start and then issues
// one output word per cycle while the result queue has room, through the single
// four-lane dot product pipeline. A four-word command queue sits in front of
// the engine and an eight-word result queue behind it, so input and output
// stall independently; the engine pauses whenever the result queue cannot hold
// every word already in flight.
module matrix4_product_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic [m4pu_pkg::MODE_W-1:0]        mode,
    input  wire logic [m4pu_pkg::IDX_W-1:0]         elem_index,
    input  wire logic signed [m4pu_pkg::DATA_W-1:0] value,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic signed [m4pu_pkg::DATA_W-1:0]      result_value,
    output logic [m4pu_pkg::IDX_W-1:0]              result_index,
    output logic                                    last
);
    import m4pu_pkg::*;

    logic               cmd_valid;
    logic               cmd_take;
    cmd_t               cmd;
    logic [RESQ_CW-1:0] res_count;
    logic               res_push;
    res_t               res_word;
    res_t               head;

    // Front: classify and queue incoming words.
    m4pu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .mode       (mode),
        .elem_index (elem_index),
        .value      (value),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_take   (cmd_take)
    );

    // Back: operand stores, sequencer and dot product pipeline.
    m4pu_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .res_count (res_count),
        .res_push  (res_push),
        .res_word  (res_word)
    );

    // Hold finished words until the consumer pops them.
    m4pu_result_queue u_resq (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_push  (res_push),
        .res_word  (res_word),
        .res_count (res_count),
        .empty     (empty),
        .pop       (pop),
        .head      (head)
    );

    assign result_value = head.value;
    assign result_index = head.index;
    assign last         = head.last;

endmodule

`default_nettype wire

// File: sv/m4pu_front.sv
`default_nettype none

module m4pu_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [m4pu_pkg::MODE_W-1:0]   mode,
    input  wire logic [m4pu_pkg::IDX_W-1:0]    elem_index,
    input  wire logic signed [m4pu_pkg::DATA_W-1:0] value,
    output logic                               cmd_valid,
    output m4pu_pkg::cmd_t                     cmd,
    input  wire logic                          cmd_take
);
    import m4pu_pkg::*;

    cmd_t               q_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] wr_ptr_reg;
    logic [CMDQ_AW-1:0] rd_ptr_reg;
    logic [CMDQ_CW-1:0] count_reg;
    logic [CMDQ_CW-1:0] count_next;

    op_t  cls_op;
    logic cls_ok;
    logic wr_en;
    logic rd_en;

    // Decode the mode; unused codes are taken and dropped.
    always_comb
    begin
        cls_op = OP_LOAD_L;
        cls_ok = 1'b1;
        case (mode)
            MODE_LOAD_LEFT:  cls_op = OP_LOAD_L;
            MODE_LOAD_RIGHT: cls_op = OP_LOAD_R;
            MODE_MAT:        cls_op = OP_MAT;
            MODE_MVEC:       cls_op = OP_MVEC;
            MODE_SCALE:      cls_op = OP_SCALE;
            default:         cls_ok = 1'b0;
        endcase
    end

    assign full      = (count_reg == CMDQ_CW'(CMDQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign wr_en     = push && !full && cls_ok;
    assign rd_en     = cmd_take && cmd_valid;

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_reg[wr_ptr_reg] <= '{op: cls_op, idx: elem_index, value: value};
        end
    end

endmodule

`default_nettype wire

// File: sv/m4pu_result_queue.sv
`default_nettype none

module m4pu_result_queue (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          res_push,
    input  wire m4pu_pkg::res_t                res_word,
    output logic [m4pu_pkg::RESQ_CW-1:0]       res_count,
    output logic                               empty,
    input  wire logic                          pop,
    output m4pu_pkg::res_t                     head
);
    import m4pu_pkg::*;

    res_t               q_reg [RESQ_DEPTH];
    logic [RESQ_AW-1:0] wr_ptr_reg;
    logic [RESQ_AW-1:0] rd_ptr_reg;
    logic [RESQ_CW-1:0] count_reg;
    logic [RESQ_CW-1:0] count_next;
    logic               rd_en;

    assign empty     = (count_reg == '0);
    assign head      = q_reg[rd_ptr_reg];
    assign res_count = count_reg;
    assign rd_en     = pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (res_push && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !res_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // The engine only pushes when it holds a free slot, so no overflow check.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (res_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            q_reg[wr_ptr_reg] <= res_word;
        end
    end

endmodule

`default_nettype wire

// File: sv/m4pu_engine.sv
`default_nettype none

module m4pu_engine (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    input  wire m4pu_pkg::cmd_t                cmd,
    output logic                               cmd_take,
    input  wire logic [m4pu_pkg::RESQ_CW-1:0]  res_count,
    output logic                               res_push,
    output m4pu_pkg::res_t                     res_word
);
    import m4pu_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // Left store: lane k is column k, entry is row.
    // Right store: lane k holds R[c*4+k], entry is column c.
    logic signed [DATA_W-1:0] left_reg  [LANES][LANES];
    logic signed [DATA_W-1:0] right_reg [LANES][LANES];

    state_t                   state_reg;
    state_t                   state_next;
    op_t                      op_reg;
    op_t                      op_next;
    logic signed [DATA_W-1:0] scalar_reg;
    logic signed [DATA_W-1:0] scalar_next;
    logic [IDX_W-1:0]         cnt_reg;
    logic [IDX_W-1:0]         cnt_next;

    logic [LANE_AW-1:0] row;
    logic [LANE_AW-1:0] col;
    logic [LANE_AW-1:0] ld_hi;
    logic [LANE_AW-1:0] ld_lo;
    logic [OCC_W-1:0]   occ;
    logic               room;
    logic               issue;
    logic               elem_last;

    logic signed [DATA_W-1:0] opa_next [LANES];
    logic signed [DATA_W-1:0] opb_next [LANES];

    // Pipeline: operands, products, pair sums, finished result.
    logic                     v0_reg, v1_reg, v2_reg, v3_reg;
    logic [IDX_W-1:0]         idx0_reg, idx1_reg, idx2_reg;
    logic                     last0_reg, last1_reg, last2_reg;
    logic signed [DATA_W-1:0] opa_reg  [LANES];
    logic signed [DATA_W-1:0] opb_reg  [LANES];
    logic signed [PROD_W-1:0] prod_reg [LANES];
    logic signed [PAIR_W-1:0] pair_reg [2];
    res_t                     word_reg;

    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W-1:0] shifted;
    logic                    fits;
    res_t                    word_next;

    assign row   = cnt_reg[LANE_AW-1:0];
    assign col   = cnt_reg[IDX_W-1:LANE_AW];
    assign ld_hi = cmd.idx[IDX_W-1:LANE_AW];
    assign ld_lo = cmd.idx[LANE_AW-1:0];

    // Issue only while the result queue can take every word in flight.
    assign occ  = OCC_W'(res_count) + OCC_W'(v0_reg) + OCC_W'(v1_reg)
                + OCC_W'(v2_reg) + OCC_W'(v3_reg);
    assign room = (occ < OCC_W'(RESQ_DEPTH));

    assign issue     = (state_reg == ST_RUN) && room;
    assign cmd_take  = (state_reg == ST_IDLE) && cmd_valid;
    assign elem_last = (op_reg == OP_MVEC) ? (cnt_reg == MVEC_LAST)
                                           : (cnt_reg == MAT_LAST);

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        scalar_next = scalar_reg;
        cnt_next    = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && (cmd.op == OP_MAT || cmd.op == OP_MVEC ||
                                  cmd.op == OP_SCALE))
                begin
                    state_next  = ST_RUN;
                    op_next     = cmd.op;
                    scalar_next = cmd.value;
                    cnt_next    = '0;
                end
            end
            ST_RUN:
            begin
                if (issue)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (elem_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            op_reg     <= OP_MAT;
            scalar_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            scalar_reg <= scalar_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Both stores reset to zero; loads are applied in queue order.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                for (int e = 0; e < LANES; e++)
                begin
                    left_reg[k][e]  <= '0;
                    right_reg[k][e] <= '0;
                end
            end
        end
        else if (cmd_take)
        begin
            if (cmd.op == OP_LOAD_L)
            begin
                left_reg[ld_hi][ld_lo] <= cmd.value;
            end
            else if (cmd.op == OP_LOAD_R)
            begin
                right_reg[ld_lo][ld_hi] <= cmd.value;
            end
        end
    end

    // Scale uses only the lane of the current column; the others add zero.
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            opa_next[k] = left_reg[k][row];
            case (op_reg)
                OP_SCALE: opb_next[k] = (LANE_AW'(k) == col) ? scalar_reg : '0;
                default:  opb_next[k] = right_reg[k][col];
            endcase
        end
    end

    assign sum     = ACC_W'(pair_reg[0]) + ACC_W'(pair_reg[1]);
    assign shifted = sum >>> FRAC_BITS;
    assign fits    = (&shifted[ACC_W-1:DATA_W-1]) || !(|shifted[ACC_W-1:DATA_W-1]);

    always_comb
    begin
        word_next.index = idx2_reg;
        word_next.last  = last2_reg;
        if (fits)
        begin
            word_next.value = shifted[DATA_W-1:0];
        end
        else
        begin
            word_next.value = shifted[ACC_W-1] ? SAT_MIN : SAT_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= issue;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < LANES; k++)
        begin
            opa_reg[k]  <= opa_next[k];
            opb_reg[k]  <= opb_next[k];
            prod_reg[k] <= PROD_W'(opa_reg[k]) * PROD_W'(opb_reg[k]);
        end
        pair_reg[0] <= PAIR_W'(prod_reg[0]) + PAIR_W'(prod_reg[1]);
        pair_reg[1] <= PAIR_W'(prod_reg[2]) + PAIR_W'(prod_reg[3]);
        idx0_reg    <= cnt_reg;
        last0_reg   <= elem_last;
        idx1_reg    <= idx0_reg;
        last1_reg   <= last0_reg;
        idx2_reg    <= idx1_reg;
        last2_reg   <= last1_reg;
        word_reg    <= word_next;
    end

    assign res_push = v3_reg;
    assign res_word = word_reg;

endmodule

`default_nettype wire

// File: sv/m4pu_port_check.sv
`default_nettype none

module m4pu_port_check (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               push,
    input wire logic                               full,
    input wire logic [m4pu_pkg::MODE_W-1:0]        mode,
    input wire logic [m4pu_pkg::IDX_W-1:0]         elem_index,
    input wire logic signed [m4pu_pkg::DATA_W-1:0] value,
    input wire logic                               empty,
    input wire logic                               pop,
    input wire logic signed [m4pu_pkg::DATA_W-1:0] result_value,
    input wire logic [m4pu_pkg::IDX_W-1:0]         result_index,
    input wire logic                               last
);
    import m4pu_pkg::*;

    // Reset leaves both queues drained.
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty && !full)
        else $error("queues not drained after reset");

    // A final word closes either a vector (row 3) or a matrix (index 15).
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last) |-> (result_index == MVEC_LAST || result_index == MAT_LAST))
        else $error("last mark on a word that cannot end a command");

    // Index 15 only occurs in 16-word commands, where it is always the end.
    a_fifteen_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_index == MAT_LAST) |-> last)
        else $error("word at index 15 without last mark");

    // A waiting word holds until it is popped.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result_value) &&
                              $stable(result_index) && $stable(last)))
        else $error("waiting result word changed");

endmodule

bind matrix4_product_unit m4pu_port_check u_port_check (.*);

`default_nettype wire

// File: sim/matrix4_product_unit_tb.sv
`default_nettype none

module matrix4_product_unit_tb;
    import m4pu_pkg::*;

    // Modes 5 to 7 carry no operation; the block must drop them.
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;
    localparam logic signed [DATA_W-1:0] Q_TWO = 32'sh0002_0000;
    localparam logic signed [DATA_W-1:0] Q_HALF = 32'sh0000_8000;
    localparam logic signed [DATA_W-1:0] Q_LSB = 32'sd1;
    localparam logic signed [DATA_W-1:0] Q_MINUS_LSB = -32'sd1;

    localparam int STALL_LIMIT = 1500;
    localparam int LONG_HOLD = 300;
    localparam int DRAIN_CYCLES = 48;

    // Keeps its own copy of both operand stores and the words each command must return.
    class matrix_product_scoreboard;
        logic signed [DATA_W-1:0] left_m [16];
        logic signed [DATA_W-1:0] right_s [16];
        res_t awaited_words [$];
        int errors;
        int loads;
        int commands;
        int dropped;
        int checked;

        function new();
            foreach (left_m[i])
            begin
                left_m[i] = '0;
                right_s[i] = '0;
            end
            errors = 0;
            loads = 0;
            commands = 0;
            dropped = 0;
            checked = 0;
        endfunction

        // Floor-shift the exact sum, then clamp to the signed 32-bit range.
        function logic signed [DATA_W-1:0] floor_saturate(logic signed [ACC_W-1:0] sum);
            logic signed [ACC_W-1:0] q;
            q = sum >>> FRAC_BITS;
            if (q[ACC_W-1:DATA_W-1] == '0 || q[ACC_W-1:DATA_W-1] == '1)
                return q[DATA_W-1:0];
            return q[ACC_W-1] ? SAT_MIN : SAT_MAX;
        endfunction

        function void note_word(logic [MODE_W-1:0] m, logic [IDX_W-1:0] idx,
                                logic signed [DATA_W-1:0] v);
            logic signed [ACC_W-1:0] sum;
            logic [IDX_W-1:0] pos;
            case (m)
                MODE_LOAD_LEFT:
                begin
                    left_m[idx] = v;
                    loads++;
                end
                MODE_LOAD_RIGHT:
                begin
                    right_s[idx] = v;
                    loads++;
                end
                MODE_MAT:
                begin
                    commands++;
                    for (int c = 0; c < 4; c++)
                    begin
                        for (int r = 0; r < 4; r++)
                        begin
                            sum = '0;
                            for (int k = 0; k < 4; k++)
                                sum = sum + left_m[k*4 + r] * right_s[c*4 + k];
                            pos = IDX_W'(c*4 + r);
                            awaited_words.push_back(res_t'{value: floor_saturate(sum),
                                                           index: pos,
                                                           last: (pos == MAT_LAST)});
                        end
                    end
                end
                MODE_MVEC:
                begin
                    commands++;
                    // Always reads right-store entries 0 to 3, whatever they hold.
                    for (int r = 0; r < 4; r++)
                    begin
                        sum = '0;
                        for (int k = 0; k < 4; k++)
                            sum = sum + left_m[k*4 + r] * right_s[k];
                        pos = IDX_W'(r);
                        awaited_words.push_back(res_t'{value: floor_saturate(sum),
                                                       index: pos,
                                                       last: (pos == MVEC_LAST)});
                    end
                end
                MODE_SCALE:
                begin
                    commands++;
                    for (int i = 0; i < 16; i++)
                    begin
                        sum = left_m[i] * v;
                        pos = IDX_W'(i);
                        awaited_words.push_back(res_t'{value: floor_saturate(sum),
                                                       index: pos,
                                                       last: (pos == MAT_LAST)});
                    end
                end
                default: dropped++;
            endcase
        endfunction

        function void check_word(logic signed [DATA_W-1:0] v, logic [IDX_W-1:0] idx,
                                 logic lst);
            res_t want;
            if (awaited_words.size() == 0)
            begin
                $error("unexpected result word: result_value %h result_index %0d last %0b",
                       v, idx, lst);
                errors++;
                return;
            end
            want = awaited_words.pop_front();
            checked++;
            if (v !== want.value)
            begin
                $error("result_value: expected %h, actual %h", want.value, v);
                errors++;
            end
            if (idx !== want.index)
            begin
                $error("result_index: expected %0d, actual %0d", want.index, idx);
                errors++;
            end
            if (lst !== want.last)
            begin
                $error("last: expected %0b, actual %0b", want.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0] elem_index;
    logic signed [DATA_W-1:0] value;
    logic empty;
    logic pop;
    logic signed [DATA_W-1:0] result_value;
    logic [IDX_W-1:0] result_index;
    logic last;

    matrix_product_scoreboard products;

    // Idle percentages per phase; steady turns all idling off for the closing stretch.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit steady = 1'b0;
    bit hold_request = 1'b0;

    matrix4_product_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .mode(mode),
        .elem_index(elem_index),
        .value(value),
        .empty(empty),
        .pop(pop),
        .result_value(result_value),
        .result_index(result_index),
        .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Offer one word, hold it until accepted, then maybe drop push for a burst.
    task automatic send_word(input logic [MODE_W-1:0] m, input logic [IDX_W-1:0] idx,
                             input logic signed [DATA_W-1:0] v);
        int gap;
        push <= 1'b1;
        mode <= m;
        elem_index <= idx;
        value <= v;
        do @(posedge clk); while (full);
        products.note_word(m, idx, v);
        if (!steady && $urandom_range(99) < tx_idle_pct)
        begin
            // Fields carry noise while push is low; the block must ignore them.
            push <= 1'b0;
            mode <= MODE_W'($urandom);
            elem_index <= IDX_W'($urandom);
            value <= $urandom;
            gap = $urandom_range(1, 18);
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic signed [DATA_W-1:0] random_value();
        int pick;
        int near_one;
        pick = $urandom_range(9);
        near_one = int'($urandom_range(0, 1 << 19)) - (1 << 18);
        if (pick == 0)
            return SAT_MAX;
        if (pick == 1)
            return SAT_MIN;
        if (pick < 6)
            return near_one;
        return $urandom;
    endfunction

    // Mostly loads with random content, a command about every fifth word, rare spare modes.
    task automatic send_random_word();
        int pick;
        logic [MODE_W-1:0] m;
        pick = $urandom_range(99);
        if (pick < 4)
            m = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        else if (pick < 44)
            m = MODE_LOAD_LEFT;
        else if (pick < 80)
            m = MODE_LOAD_RIGHT;
        else if (pick < 88)
            m = MODE_MAT;
        else if (pick < 94)
            m = MODE_MVEC;
        else
            m = MODE_SCALE;
        send_word(m, IDX_W'($urandom_range(15)), random_value());
    endtask

    // Result side: check every popped word, idle in bursts, honor one long hold.
    initial
    begin : result_side
        int burst_left;
        int hold_left;
        bit hold_taken;
        burst_left = 0;
        hold_left = 0;
        hold_taken = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                products.check_word(result_value, result_index, last);
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (!steady && burst_left > 0)
            begin
                burst_left--;
                pop <= 1'b0;
            end
            else if (!steady && $urandom_range(99) < rx_idle_pct)
            begin
                burst_left = $urandom_range(1, 18) - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // End the run if no word moves on either side for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $error("no word accepted for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        mode = '0;
        elem_index = '0;
        value = '0;
        products = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: commands on the cleared stores, extreme loads, overflow both ways,
        // floor of a negative sum, spare modes, and a stale vector.
        tx_idle_pct = 30;
        rx_idle_pct = 30;
        send_word(MODE_MVEC, 4'd15, SAT_MIN);
        send_word(MODE_SCALE, 4'd0, SAT_MAX);
        send_word(MODE_LOAD_LEFT, 4'd0, SAT_MAX);
        send_word(MODE_LOAD_LEFT, 4'd15, SAT_MIN);
        send_word(MODE_LOAD_LEFT, 4'd5, Q_ONE);
        send_word(MODE_LOAD_LEFT, 4'd10, Q_MINUS_LSB);
        send_word(MODE_LOAD_RIGHT, 4'd0, SAT_MAX);
        send_word(MODE_LOAD_RIGHT, 4'd15, SAT_MIN);
        send_word(MODE_LOAD_RIGHT, 4'd3, Q_MINUS_LSB);
        send_word(MODE_LOAD_RIGHT, 4'd5, Q_ONE);
        send_word(MODE_LOAD_RIGHT, 4'd12, SAT_MIN);
        send_word(MODE_MAT, 4'd0, SAT_MAX);
        send_word(MODE_MVEC, 4'd0, '0);
        send_word(MODE_SCALE, 4'd15, SAT_MIN);
        send_word(MODE_SCALE, 4'd0, Q_LSB);
        send_word(MODE_SPARE_LO, 4'd15, SAT_MAX);
        send_word(MODE_SPARE_HI, 4'd0, SAT_MIN);
        send_word(MODE_LOAD_RIGHT, 4'd1, Q_TWO);
        send_word(MODE_MVEC, 4'd7, Q_ONE);
        send_word(MODE_LOAD_LEFT, 4'd0, Q_HALF);
        send_word(MODE_MVEC, 4'd3, Q_HALF);
        send_word(MODE_MAT, 4'd15, Q_MINUS_LSB);

        repeat (60) send_random_word();

        // Slow receiver, eager sender.
        tx_idle_pct = 0;
        rx_idle_pct = 50;
        repeat (50) send_random_word();

        // Long receiver hold while commands keep coming, so the input side backs up.
        hold_request = 1'b1;
        repeat (12) send_word($urandom_range(1) ? MODE_MAT : MODE_SCALE,
                              IDX_W'($urandom_range(15)), random_value());

        tx_idle_pct = 50;
        rx_idle_pct = 10;
        repeat (60) send_random_word();

        // Closing stretch at full rate on both sides.
        steady = 1'b1;
        repeat (40) send_random_word();
        push <= 1'b0;

        while (products.awaited_words.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d loads, %0d commands and %0d words in unused modes.",
                 products.loads, products.commands, products.dropped);
        $display("Checked %0d result words against predicted products.", products.checked);
        if (products.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
